// ===== rtl/rws_pkg.sv =====
package rws_pkg;

    // Field widths fixed by the item formats
    localparam int CMD_W   = 1;
    localparam int SLOT_W  = 5;
    localparam int FIT_W   = 16;
    localparam int DRAW_W  = 16;
    localparam int PICK_W  = 5;

    localparam int DEF_POP_ENTRIES = 32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD   = 1'b0;
    localparam logic [CMD_W-1:0] CMD_SELECT = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [SLOT_W-1:0] slot;
        logic [FIT_W-1:0]  fitness_value;
        logic [DRAW_W-1:0] random_draw;
    } rws_in_t;

    typedef struct packed {
        logic [PICK_W-1:0] picked_slot;
        logic              total_zero;
    } rws_out_t;

    // Control part of the token that walks the cell chain
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [PICK_W-1:0] pick;
    } rws_tok_t;

endpackage

// ===== rtl/rws_cell.sv =====
module rws_cell
    import rws_pkg::*;
#(
    parameter int SUM_W    = FIT_W + 5,
    parameter int LHS_W    = DRAW_W + SUM_W,
    parameter int CELL_IDX = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             ld_en,
    input  logic [FIT_W-1:0] ld_value,
    output logic [FIT_W-1:0] fit_out,
    input  logic [LHS_W-1:0] lhs,
    input  rws_tok_t         tok_in,
    input  logic [SUM_W-1:0] prefix_in,
    output rws_tok_t         tok_out,
    output logic [SUM_W-1:0] prefix_out
);

    logic [FIT_W-1:0] fit_reg, fit_next;
    rws_tok_t         tok_reg, tok_next;
    logic [SUM_W-1:0] prefix_reg, prefix_next;
    logic [LHS_W-1:0] scaled;
    logic             hit;

    // Slot storage, cleared by reset
    always_comb begin
        fit_next = fit_reg;
        if (ld_en) begin
            fit_next = ld_value;
        end
    end

    // Prefix sum step and threshold test: lhs <= prefix * 65535
    always_comb begin
        prefix_next = prefix_in + SUM_W'(fit_reg);
        scaled      = {prefix_next, {DRAW_W{1'b0}}} - LHS_W'(prefix_next);
        hit         = (lhs <= scaled);
        tok_next    = tok_in;
        if (tok_in.valid && !tok_in.found && hit) begin
            tok_next.found = 1'b1;
            tok_next.pick  = PICK_W'(CELL_IDX);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_reg       <= '0;
            tok_reg.valid <= 1'b0;
        end else begin
            fit_reg       <= fit_next;
            tok_reg.valid <= tok_next.valid;
        end
        tok_reg.found <= tok_next.found;
        tok_reg.pick  <= tok_next.pick;
        prefix_reg    <= prefix_next;
    end

    assign fit_out    = fit_reg;
    assign tok_out    = tok_reg;
    assign prefix_out = prefix_reg;

endmodule

// ===== rtl/roulette_wheel_selector_top.sv =====
// Channel   Ports                      Direction  Payload
// input     s_valid, s_ready, s_data   in         rws_in_t  (cmd, slot, fitness_value, random_draw)
// result    m_valid, m_ready, m_data   out        rws_out_t (picked_slot, total_zero)
//
// A load transfer gives no result; the block is ready again at once.
// A select result becomes valid after these steps: draw * total is registered, a token walks
// the cell chain through one register per slot, the pick is collected, and it goes to the output.
// A select with zero total skips the multiply and the walk; its result is held, then registered to the output.
// aresetn (synchronous) clears all slots, the total and every valid flag.
// Input is taken only while no select is in progress; a result waiting on m_ready stalls it.
module roulette_wheel_selector_top
    import rws_pkg::*;
#(
    parameter int POP_ENTRIES = DEF_POP_ENTRIES
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  rws_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output rws_out_t m_data
);

    localparam int SUM_W = FIT_W + $clog2(POP_ENTRIES);
    localparam int LHS_W = DRAW_W + SUM_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MULT = 4'b0010,
        ST_WALK = 4'b0100,
        ST_HOLD = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [DRAW_W-1:0] draw_reg, draw_next;
    logic [LHS_W-1:0]  lhs_reg, lhs_next;
    logic              start_reg, start_next;
    rws_out_t          pend_reg, pend_next;
    rws_out_t          m_data_reg, m_data_next;
    logic              m_valid_reg, m_valid_next;

    logic                   in_fire, load_fire;
    logic [POP_ENTRIES-1:0] ld_hit;
    logic [FIT_W-1:0]       fit_vec [POP_ENTRIES];
    logic [FIT_W-1:0]       old_fit;
    rws_tok_t               tok     [POP_ENTRIES+1];
    logic [SUM_W-1:0]       prefix  [POP_ENTRIES+1];

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign load_fire = in_fire && (s_data.cmd == CMD_LOAD);

    // Chain head: a fresh token starts after the multiply
    assign tok[0].valid = start_reg;
    assign tok[0].found = 1'b0;
    assign tok[0].pick  = '0;
    assign prefix[0]    = '0;

    // Row of slot cells
    for (genvar i = 0; i < POP_ENTRIES; i++) begin : g_cell
        assign ld_hit[i] = load_fire && (32'(s_data.slot) == i);

        rws_cell #(
            .SUM_W    (SUM_W),
            .LHS_W    (LHS_W),
            .CELL_IDX (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ld_en      (ld_hit[i]),
            .ld_value   (s_data.fitness_value),
            .fit_out    (fit_vec[i]),
            .lhs        (lhs_reg),
            .tok_in     (tok[i]),
            .prefix_in  (prefix[i]),
            .tok_out    (tok[i+1]),
            .prefix_out (prefix[i+1])
        );
    end

    // Old value of the slot being reloaded
    always_comb begin
        old_fit = '0;
        for (int k = 0; k < POP_ENTRIES; k++) begin
            old_fit = old_fit | (fit_vec[k] & {FIT_W{ld_hit[k]}});
        end
    end

    // Control and running total
    always_comb begin
        state_next   = state_reg;
        sum_next     = sum_reg;
        draw_next    = draw_reg;
        lhs_next     = lhs_reg;
        start_next   = 1'b0;
        pend_next    = pend_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (load_fire && (|ld_hit)) begin
                    sum_next = sum_reg - SUM_W'(old_fit) + SUM_W'(s_data.fitness_value);
                end
                if (in_fire && (s_data.cmd == CMD_SELECT)) begin
                    draw_next = s_data.random_draw;
                    if (sum_reg == '0) begin
                        pend_next.picked_slot = '0;
                        pend_next.total_zero  = 1'b1;
                        state_next            = ST_HOLD;
                    end else begin
                        state_next = ST_MULT;
                    end
                end
            end
            ST_MULT: begin
                lhs_next   = LHS_W'(draw_reg) * LHS_W'(sum_reg);
                start_next = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (tok[POP_ENTRIES].valid) begin
                    pend_next.picked_slot = tok[POP_ENTRIES].pick;
                    pend_next.total_zero  = 1'b0;
                    state_next            = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = pend_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sum_reg     <= '0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
        end
        draw_reg   <= draw_next;
        lhs_reg    <= lhs_next;
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A walk only starts with a nonzero total
    a_start_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg |-> (sum_reg != '0))
        else $error("walk started with zero total");

    // A token leaving the chain always carries a choice
    a_walk_found: assert property (@(posedge aclk) disable iff (!aresetn)
        tok[POP_ENTRIES].valid |-> tok[POP_ENTRIES].found)
        else $error("walk finished without a slot");

    // The chain only carries a token during a walk
    a_tok_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        tok[POP_ENTRIES].valid |-> (state_reg == ST_WALK))
        else $error("token left chain outside a walk");

    // Zero total reports slot zero
    a_zero_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.total_zero) |-> (m_data.picked_slot == '0))
        else $error("zero total with nonzero slot");

    // Total is stable while a select is in progress
    a_sum_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |=> $stable(sum_reg))
        else $error("total changed during walk");

endmodule

// ===== tb/testbench.sv =====
module testbench
    import rws_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_SLOTS      = DEF_POP_ENTRIES;
    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TAIL_CYCLES  = N_SLOTS + 12;
    localparam int MAX_IDLE     = 19;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    rws_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    rws_out_t m_data;

    // Local copy of the wheel
    logic [FIT_W-1:0] fit_table [N_SLOTS];
    logic [31:0]      fit_total;
    rws_out_t         expected_picks[$];
    rws_out_t         head_pick;

    // Random idling on both sides; cleared for burst stretches
    bit idle_on = 1'b0;

    int cycle_count     = 0;
    int items_sent      = 0;
    int loads_sent      = 0;
    int selects_sent    = 0;
    int empty_selects   = 0;
    int results_checked = 0;
    int errors          = 0;

    roulette_wheel_selector_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d picks outstanding",
                     cycle_count, expected_picks.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Expected pick for a draw against the current wheel.
    // First slot whose prefix sum S meets draw*total <= S*65535.
    function automatic rws_out_t spin_wheel(input logic [DRAW_W-1:0] draw);
        rws_out_t    res;
        logic [63:0] target;
        logic [63:0] running;
        res = '0;
        if (fit_total == 0) begin
            res.total_zero = 1'b1;
            return res;
        end
        target  = 64'(draw) * 64'(fit_total);
        running = '0;
        res.picked_slot = PICK_W'(N_SLOTS - 1);
        for (int i = 0; i < N_SLOTS; i++) begin
            running += 64'(fit_table[i]);
            if (target <= running * 64'd65535) begin
                res.picked_slot = PICK_W'(i);
                return res;
            end
        end
        return res;
    endfunction

    // Apply one accepted transfer to the local wheel
    function automatic void update_wheel(input rws_in_t it);
        if (it.cmd == CMD_LOAD) begin
            loads_sent++;
            if (int'(it.slot) < N_SLOTS) begin
                fit_total = fit_total - 32'(fit_table[it.slot]) + 32'(it.fitness_value);
                fit_table[it.slot] = it.fitness_value;
            end
        end else begin
            selects_sent++;
            if (fit_total == 0)
                empty_selects++;
            expected_picks.push_back(spin_wheel(it.random_draw));
        end
    endfunction

    // Drive one item and wait for its transfer
    task automatic send_item(input rws_in_t it);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        update_wheel(it);
    endtask

    task automatic load_slot(input int slot, input logic [FIT_W-1:0] value,
                             input logic [DRAW_W-1:0] junk_draw);
        rws_in_t it;
        it.cmd           = CMD_LOAD;
        it.slot          = SLOT_W'(slot);
        it.fitness_value = value;
        it.random_draw   = junk_draw;
        send_item(it);
    endtask

    task automatic select_draw(input logic [DRAW_W-1:0] draw,
                               input logic [SLOT_W-1:0] junk_slot,
                               input logic [FIT_W-1:0] junk_fit);
        rws_in_t it;
        it.cmd           = CMD_SELECT;
        it.slot          = junk_slot;
        it.fitness_value = junk_fit;
        it.random_draw   = draw;
        send_item(it);
    endtask

    function automatic logic [FIT_W-1:0] rand_fitness();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return FIT_W'($urandom_range(1, 15));
            default: return FIT_W'($urandom);
        endcase
    endfunction

    function automatic logic [DRAW_W-1:0] rand_draw();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return DRAW_W'(1);
            3: return DRAW_W'(16'hFFFE);
            default: return DRAW_W'($urandom);
        endcase
    endfunction

    // Result side: random stall before each transfer
    initial begin
        int stall;
        forever begin
            stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // Compare each result transfer with the oldest expected pick
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (expected_picks.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: picked_slot=%0d total_zero=%0b",
                             m_data.picked_slot, m_data.total_zero);
            end else begin
                head_pick = expected_picks.pop_front();
                if (m_data.picked_slot !== head_pick.picked_slot ||
                    m_data.total_zero !== head_pick.total_zero) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch %0d: expected slot=%0d zero=%0b, got slot=%0d zero=%0b",
                                 results_checked, head_pick.picked_slot,
                                 head_pick.total_zero, m_data.picked_slot,
                                 m_data.total_zero);
                end
            end
        end
    end

    // Selects against an empty wheel
    task automatic test_empty_wheel();
        select_draw('0, '0, '0);
        select_draw('1, '1, '1);
    endtask

    // Field extremes, draw of zero, unused fields set
    task automatic test_field_extremes();
        load_slot(N_SLOTS - 1, '1, '1);
        load_slot(0, '0, DRAW_W'(16'h5A5A));
        select_draw('0, '1, '1);          // slot 0 wins on zero draw despite zero fitness
        select_draw(DRAW_W'(1), '0, '0);
        select_draw('1, 5'h15, 16'hA5A5);
        load_slot(0, '1, '0);
        select_draw(DRAW_W'(32767), '0, '0);
        select_draw(DRAW_W'(32768), '0, '0);
    endtask

    // Reloads replace the old value and adjust the total
    task automatic test_reload();
        load_slot(15, FIT_W'(1), '0);
        load_slot(N_SLOTS - 1, '0, '0);
        select_draw('1, '0, '0);          // lands on the one-count middle slot
        select_draw(DRAW_W'(16'hFFFE), '0, '0);
        load_slot(0, '0, '0);
        load_slot(15, '0, '0);
        select_draw(DRAW_W'($urandom), '0, '0);
        idle_on = 1'b1;
        load_slot(7, FIT_W'(3), '0);
        select_draw('0, '0, '0);
        select_draw('1, '0, '0);
    endtask

    // Random mix of well-formed load/select sequences plus noise
    task automatic test_random_mix();
        int start;
        int kind;
        bit all_max;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            kind    = $urandom_range(0, 9);
            if (kind < 4) begin
                // partial refill, then draw
                repeat ($urandom_range(1, 8))
                    load_slot($urandom_range(0, N_SLOTS - 1), rand_fitness(), DRAW_W'($urandom));
                repeat ($urandom_range(1, 6))
                    select_draw(rand_draw(), SLOT_W'($urandom), FIT_W'($urandom));
            end else if (kind == 4) begin
                // whole table, sometimes every slot at full scale
                all_max = ($urandom_range(0, 2) == 0);
                for (int i = 0; i < N_SLOTS; i++)
                    load_slot(i, all_max ? '1 : rand_fitness(), DRAW_W'($urandom));
                repeat ($urandom_range(2, 8))
                    select_draw(rand_draw(), SLOT_W'($urandom), FIT_W'($urandom));
            end else if (kind == 5) begin
                // clear the wheel, leave a sparse set behind
                for (int i = 0; i < N_SLOTS; i++)
                    if (fit_table[i] != 0)
                        load_slot(i, '0, DRAW_W'($urandom));
                select_draw(rand_draw(), SLOT_W'($urandom), FIT_W'($urandom));
                repeat ($urandom_range(1, 3))
                    load_slot($urandom_range(0, N_SLOTS - 1), rand_fitness(), '0);
            end else if (kind < 9) begin
                repeat ($urandom_range(1, 12))
                    select_draw(rand_draw(), SLOT_W'($urandom), FIT_W'($urandom));
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    rws_in_t it;
                    it.cmd           = CMD_W'($urandom);
                    it.slot          = SLOT_W'($urandom);
                    it.fitness_value = FIT_W'($urandom);
                    it.random_draw   = DRAW_W'($urandom);
                    send_item(it);
                end
            end
        end
    endtask

    initial begin
        for (int i = 0; i < N_SLOTS; i++)
            fit_table[i] = '0;
        fit_total = '0;

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_wheel();
        test_field_extremes();
        test_reload();
        test_random_mix();

        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_picks.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d loads and %0d selects, %0d of them on an empty wheel",
                 loads_sent, selects_sent, empty_selects);
        $display("%0d results checked, %0d errors", results_checked, errors);
        if (errors == 0 && expected_picks.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rws_pkg.sv
rtl/rws_cell.sv
rtl/roulette_wheel_selector_top.sv
tb/testbench.sv
